@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the slab allocator RTL.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define SOA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition checked on every rising edge outside reset.
`define SOA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

@@ rtl/core/soa_pkg.sv @@
// Types and constants of the slab object allocator.
// Depends on nothing; used by slab_object_allocator_top.
package soa_pkg;

    localparam int NUM_FRAMES   = 64;
    localparam int FRAME_W      = 6;
    localparam int MAP_W        = 128;
    localparam int BIT_W        = 7;
    localparam int CHUNK_W      = 4;
    localparam int PAGE_SHIFT   = 12;
    localparam int HEADER_BYTES = 40;
    localparam int ADDR_W       = 18;
    localparam int CNT_W        = 7;
    localparam int SIZE_W       = 12;
    localparam int AGE_W        = 32;
    localparam int SPAN_W       = 19;
    localparam int NUM_CLASSES  = 3;

    localparam logic [2:0] ST_ALLOC     = 3'd0;
    localparam logic [2:0] ST_NO_CLASS  = 3'd1;
    localparam logic [2:0] ST_NO_FRAME  = 3'd2;
    localparam logic [2:0] ST_FREED     = 3'd3;
    localparam logic [2:0] ST_FREED_REL = 3'd4;
    localparam logic [2:0] ST_IGNORED   = 3'd5;

    localparam logic [2:0] CFG_SIZE_SMALL  = 3'd0;
    localparam logic [2:0] CFG_SIZE_MID    = 3'd1;
    localparam logic [2:0] CFG_SIZE_LARGE  = 3'd2;
    localparam logic [2:0] CFG_COUNT_SMALL = 3'd3;
    localparam logic [2:0] CFG_COUNT_MID   = 3'd4;
    localparam logic [2:0] CFG_COUNT_LARGE = 3'd5;
    localparam logic [2:0] CFG_POOL        = 3'd6;

    localparam logic [0:0] KIND_ALLOC = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [15:0] request_size;
        logic [17:0] object_address;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [17:0] result_address;
        logic [6:0]  free_frames;
    } rsp_t;

    typedef struct packed {
        logic [1:0]       cls;
        logic [AGE_W-1:0] age;
        logic [CNT_W-1:0] free_obj;
    } frame_info_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
        return (n == '0) ? CNT_W'(1) : n;
    endfunction

endpackage

@@ rtl/core/slab_object_allocator_top.sv @@
// Slab object allocator: one transaction at a time, the response raised after the steps below.
// Each request scans the frame table (not for an allocate with no fitting class), counts free frames
// and raises the response; a free first computes the class spans and, after the scan, runs the divider
// and bit update, and an allocate into an existing slab adds the bitmap search and address.
// The next request can be accepted in the same cycle that the response is raised. Reset clears the live
// bits and the age counter and restores the default configuration; the frame table is not cleared.
`include "assert_macros.svh"

module slab_object_allocator_top
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  soa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output soa_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [11:0]   cfg_wdata
);

    typedef enum logic [9:0]
    {
        S_IDLE  = 10'b0000000001,
        S_SPAN  = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_BSRCH = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_ADDR  = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_FUPD  = 10'b0010000000,
        S_COUNT = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [soa_pkg::SIZE_W-1:0] size_reg  [soa_pkg::NUM_CLASSES];
    logic [soa_pkg::CNT_W-1:0]  count_reg [soa_pkg::NUM_CLASSES];
    logic [6:0]                 pool_reg;

    logic                        kind_reg;
    logic [soa_pkg::ADDR_W-1:0]  addr_in_reg;
    logic [1:0]                  cls_reg;
    logic [soa_pkg::CNT_W-1:0]   cnt_cur_reg;
    logic [soa_pkg::SPAN_W-1:0]  span_reg [soa_pkg::NUM_CLASSES];
    logic [1:0]                  mul_k_reg;
    logic [6:0]                  scan_idx_reg;
    logic                        rd_valid_reg;
    logic [soa_pkg::FRAME_W-1:0] rd_idx_reg;
    logic                        best_found_reg;
    logic [soa_pkg::FRAME_W-1:0] best_f_reg;
    logic [33:0]                 best_key_reg;
    logic [soa_pkg::MAP_W-1:0]   best_map_reg;
    soa_pkg::frame_info_t        best_info_reg;
    logic [soa_pkg::ADDR_W-1:0]  best_off_reg;
    logic                        new_found_reg;
    logic [soa_pkg::FRAME_W-1:0] new_f_reg;
    logic [soa_pkg::CHUNK_W-1:0] chunk_reg;
    logic [soa_pkg::BIT_W-1:0]   bit_idx_reg;
    logic [soa_pkg::SPAN_W-1:0]  prod_reg;
    logic [soa_pkg::ADDR_W-1:0]  rem_reg;
    logic [soa_pkg::BIT_W-1:0]   q_reg;
    logic [2:0]                  step_reg;
    logic [soa_pkg::AGE_W-1:0]   counter_reg;
    logic [soa_pkg::NUM_FRAMES-1:0] live_reg;
    logic [6:0]                  cidx_reg;
    logic [6:0]                  fcount_reg;
    logic [2:0]                  status_reg;
    logic [soa_pkg::ADDR_W-1:0]  raddr_reg;
    logic                        rsp_valid_reg;
    soa_pkg::rsp_t               rsp_reg;

    soa_pkg::frame_info_t        info_mem [soa_pkg::NUM_FRAMES];
    logic [soa_pkg::MAP_W-1:0]   map_mem  [soa_pkg::NUM_FRAMES];
    soa_pkg::frame_info_t        info_q;
    logic [soa_pkg::MAP_W-1:0]   map_q;
    logic                        mem_we;
    logic [soa_pkg::FRAME_W-1:0] mem_wa;
    soa_pkg::frame_info_t        info_wd;
    logic [soa_pkg::MAP_W-1:0]   map_wd;
    logic [soa_pkg::FRAME_W-1:0] mem_ra;

    logic                        accept;
    logic [6:0]                  lim;
    logic                        cls_hit [soa_pkg::NUM_CLASSES];
    logic [1:0]                  cls_pick;
    logic                        cls_any;
    logic [soa_pkg::MAP_W-1:0]   cnt_mask;
    logic                        lv;
    logic [soa_pkg::ADDR_W-1:0]  lo;
    logic [soa_pkg::ADDR_W:0]    off;
    logic [soa_pkg::SPAN_W-1:0]  span_sel;
    logic [soa_pkg::AGE_W-1:0]   age_dist;
    logic                        elig;
    logic [33:0]                 key;
    logic                        take;
    logic                        newf;
    logic                        scan_done;
    logic [soa_pkg::SPAN_W-1:0]  mul_p;
    logic [7:0]                  chunk_ok;
    logic [2:0]                  chunk_pos;
    logic [soa_pkg::ADDR_W-1:0]  div_sh;
    logic                        div_ge;
    logic [soa_pkg::CNT_W-1:0]   free_inc;
    logic [19:0]                 addr_sum;
    logic                        emit_go;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign lim       = (pool_reg > 7'(soa_pkg::NUM_FRAMES)) ? 7'(soa_pkg::NUM_FRAMES) : pool_reg;
    assign emit_go   = (state_reg == S_EMIT) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        cls_pick = 2'd0;
        cls_any  = 1'b0;
        for (int k = soa_pkg::NUM_CLASSES - 1; k >= 0; k--)
        begin
            cls_hit[k] = (req.request_size != '0) && ({4'd0, size_reg[k]} >= req.request_size);
            if (cls_hit[k])
            begin
                cls_pick = 2'(k);
                cls_any  = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < soa_pkg::MAP_W; i++)
        begin
            cnt_mask[i] = (8'(i) < {1'b0, cnt_cur_reg});
        end
    end

    assign lv       = live_reg[rd_idx_reg];
    assign lo       = {rd_idx_reg, 12'd0} + soa_pkg::ADDR_W'(soa_pkg::HEADER_BYTES);
    assign off      = {1'b0, addr_in_reg} - {1'b0, lo};
    assign span_sel = (info_q.cls == 2'd0) ? span_reg[0] :
                      (info_q.cls == 2'd1) ? span_reg[1] : span_reg[2];
    assign age_dist = counter_reg - info_q.age;

    always_comb
    begin
        if (kind_reg == soa_pkg::KIND_ALLOC)
        begin
            elig = lv && (info_q.cls == cls_reg) && (info_q.free_obj != '0)
                && ((~map_q & cnt_mask) != '0);
            key  = {2'd0, age_dist};
        end
        else
        begin
            elig = lv && (info_q.cls != 2'd3) && !off[soa_pkg::ADDR_W]
                && ({1'b0, off[soa_pkg::ADDR_W-1:0]} < span_sel);
            key  = {info_q.cls, age_dist};
        end
        take = rd_valid_reg && elig && (!best_found_reg || (key < best_key_reg));
        newf = rd_valid_reg && (kind_reg == soa_pkg::KIND_ALLOC) && !lv
            && ({1'b0, rd_idx_reg} < lim) && !new_found_reg;
    end

    assign scan_done = (scan_idx_reg == 7'(soa_pkg::NUM_FRAMES)) && !rd_valid_reg;
    assign mem_ra    = scan_idx_reg[soa_pkg::FRAME_W-1:0];

    always_comb
    begin
        if (state_reg == S_SPAN)
        begin
            mul_p = size_reg[mul_k_reg] * soa_pkg::SPAN_W'(soa_pkg::eff_count(count_reg[mul_k_reg]));
        end
        else
        begin
            mul_p = size_reg[cls_reg] * soa_pkg::SPAN_W'(bit_idx_reg);
        end
    end

    always_comb
    begin
        chunk_pos = 3'd0;
        for (int j = 7; j >= 0; j--)
        begin
            chunk_ok[j] = !best_map_reg[{chunk_reg, 3'(j)}]
                && ({chunk_reg, 3'(j)} < cnt_cur_reg);
            if (chunk_ok[j])
            begin
                chunk_pos = 3'(j);
            end
        end
    end

    assign div_sh   = soa_pkg::ADDR_W'(size_reg[cls_reg]) << step_reg;
    assign div_ge   = rem_reg >= div_sh;
    assign free_inc = (best_info_reg.free_obj == 7'd127) ? 7'd127 : best_info_reg.free_obj + 7'd1;
    assign addr_sum = {2'd0, best_f_reg, 12'd0} + 20'(soa_pkg::HEADER_BYTES) + {1'b0, prod_reg};

    always_comb
    begin
        mem_we  = 1'b0;
        mem_wa  = best_f_reg;
        info_wd = best_info_reg;
        map_wd  = best_map_reg;
        if (state_reg == S_SCAN && scan_done && kind_reg == soa_pkg::KIND_ALLOC
            && !best_found_reg && new_found_reg)
        begin
            mem_we           = 1'b1;
            mem_wa           = new_f_reg;
            info_wd.cls      = cls_reg;
            info_wd.age      = counter_reg;
            info_wd.free_obj = cnt_cur_reg - 7'd1;
            map_wd           = soa_pkg::MAP_W'(1);
        end
        else if (state_reg == S_MUL)
        begin
            mem_we              = 1'b1;
            map_wd[bit_idx_reg] = 1'b1;
            info_wd.free_obj    = best_info_reg.free_obj - 7'd1;
        end
        else if (state_reg == S_FUPD && best_map_reg[q_reg])
        begin
            mem_we           = 1'b1;
            map_wd[q_reg]    = 1'b0;
            info_wd.free_obj = free_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            info_mem[mem_wa] <= info_wd;
            map_mem[mem_wa]  <= map_wd;
        end
        info_q <= info_mem[mem_ra];
        map_q  <= map_mem[mem_ra];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind != soa_pkg::KIND_ALLOC)
                    begin
                        state_next = S_SPAN;
                    end
                    else if (cls_any)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_COUNT;
                    end
                end
            end
            S_SPAN:
            begin
                if (mul_k_reg == 2'(soa_pkg::NUM_CLASSES - 1))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    if (!best_found_reg)
                    begin
                        state_next = S_COUNT;
                    end
                    else if (kind_reg == soa_pkg::KIND_ALLOC)
                    begin
                        state_next = S_BSRCH;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_BSRCH:
            begin
                if (chunk_ok != '0)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_ADDR;
            S_ADDR:  state_next = S_COUNT;
            S_DIV:
            begin
                if (step_reg == 3'd0)
                begin
                    state_next = S_FUPD;
                end
            end
            S_FUPD:  state_next = S_COUNT;
            S_COUNT:
            begin
                if (cidx_reg == 7'(soa_pkg::NUM_FRAMES))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            size_reg[0]    <= 12'd32;
            size_reg[1]    <= 12'd64;
            size_reg[2]    <= 12'd128;
            count_reg[0]   <= 7'd126;
            count_reg[1]   <= 7'd63;
            count_reg[2]   <= 7'd31;
            pool_reg       <= 7'd64;
            counter_reg    <= '0;
            live_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            rd_valid_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            new_found_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    soa_pkg::CFG_SIZE_SMALL:  size_reg[0]  <= cfg_wdata;
                    soa_pkg::CFG_SIZE_MID:    size_reg[1]  <= cfg_wdata;
                    soa_pkg::CFG_SIZE_LARGE:  size_reg[2]  <= cfg_wdata;
                    soa_pkg::CFG_COUNT_SMALL: count_reg[0] <= cfg_wdata[6:0];
                    soa_pkg::CFG_COUNT_MID:   count_reg[1] <= cfg_wdata[6:0];
                    soa_pkg::CFG_COUNT_LARGE: count_reg[2] <= cfg_wdata[6:0];
                    soa_pkg::CFG_POOL:        pool_reg     <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (rsp_valid_reg && !rsp_stall && !emit_go)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg       <= req.kind;
                        addr_in_reg    <= req.object_address;
                        cls_reg        <= cls_pick;
                        cnt_cur_reg    <= soa_pkg::eff_count(count_reg[cls_pick]);
                        mul_k_reg      <= 2'd0;
                        scan_idx_reg   <= '0;
                        rd_valid_reg   <= 1'b0;
                        best_found_reg <= 1'b0;
                        new_found_reg  <= 1'b0;
                        status_reg     <= soa_pkg::ST_NO_CLASS;
                        raddr_reg      <= '0;
                        cidx_reg       <= '0;
                        fcount_reg     <= '0;
                    end
                end
                S_SPAN:
                begin
                    span_reg[mul_k_reg] <= mul_p;
                    mul_k_reg           <= mul_k_reg + 2'd1;
                end
                S_SCAN:
                begin
                    if (scan_idx_reg != 7'(soa_pkg::NUM_FRAMES))
                    begin
                        rd_valid_reg <= 1'b1;
                        rd_idx_reg   <= scan_idx_reg[soa_pkg::FRAME_W-1:0];
                        scan_idx_reg <= scan_idx_reg + 7'd1;
                    end
                    else
                    begin
                        rd_valid_reg <= 1'b0;
                    end
                    if (take)
                    begin
                        best_found_reg <= 1'b1;
                        best_f_reg     <= rd_idx_reg;
                        best_key_reg   <= key;
                        best_map_reg   <= map_q;
                        best_info_reg  <= info_q;
                        best_off_reg   <= off[soa_pkg::ADDR_W-1:0];
                    end
                    if (newf)
                    begin
                        new_found_reg <= 1'b1;
                        new_f_reg     <= rd_idx_reg;
                    end
                    if (scan_done)
                    begin
                        chunk_reg <= '0;
                        rem_reg   <= best_off_reg;
                        q_reg     <= '0;
                        step_reg  <= 3'd6;
                        if (kind_reg != soa_pkg::KIND_ALLOC)
                        begin
                            cls_reg     <= best_info_reg.cls;
                            cnt_cur_reg <= soa_pkg::eff_count(count_reg[best_info_reg.cls]);
                            status_reg  <= soa_pkg::ST_IGNORED;
                        end
                        else if (!best_found_reg && new_found_reg)
                        begin
                            live_reg[new_f_reg] <= 1'b1;
                            counter_reg         <= counter_reg + 32'd1;
                            status_reg          <= soa_pkg::ST_ALLOC;
                            raddr_reg           <= {new_f_reg, 12'd0}
                                + soa_pkg::ADDR_W'(soa_pkg::HEADER_BYTES);
                        end
                        else
                        begin
                            status_reg <= soa_pkg::ST_NO_FRAME;
                        end
                    end
                end
                S_BSRCH:
                begin
                    bit_idx_reg <= {chunk_reg, chunk_pos};
                    chunk_reg   <= chunk_reg + 4'd1;
                end
                S_MUL:
                begin
                    prod_reg <= mul_p;
                end
                S_ADDR:
                begin
                    status_reg <= soa_pkg::ST_ALLOC;
                    raddr_reg  <= addr_sum[soa_pkg::ADDR_W-1:0];
                end
                S_DIV:
                begin
                    if (div_ge)
                    begin
                        rem_reg         <= rem_reg - div_sh;
                        q_reg[step_reg] <= 1'b1;
                    end
                    step_reg <= step_reg - 3'd1;
                end
                S_FUPD:
                begin
                    if (!best_map_reg[q_reg])
                    begin
                        status_reg <= soa_pkg::ST_IGNORED;
                    end
                    else if (free_inc == cnt_cur_reg)
                    begin
                        live_reg[best_f_reg] <= 1'b0;
                        status_reg           <= soa_pkg::ST_FREED_REL;
                    end
                    else
                    begin
                        status_reg <= soa_pkg::ST_FREED;
                    end
                end
                S_COUNT:
                begin
                    if (cidx_reg != 7'(soa_pkg::NUM_FRAMES))
                    begin
                        if (!live_reg[cidx_reg[soa_pkg::FRAME_W-1:0]] && (cidx_reg < lim))
                        begin
                            fcount_reg <= fcount_reg + 7'd1;
                        end
                        cidx_reg <= cidx_reg + 7'd1;
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        rsp_valid_reg          <= 1'b1;
                        rsp_reg.status         <= status_reg;
                        rsp_reg.result_address <= (status_reg == soa_pkg::ST_ALLOC) ? raddr_reg : '0;
                        rsp_reg.free_frames    <= fcount_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    `SOA_ASSERT(a_busy_after_accept, (req_valid && !req_stall) |=> req_stall, "idle after accept")
    `SOA_ASSERT(a_addr_zero, (rsp_valid && rsp.status != soa_pkg::ST_ALLOC) |-> (rsp.result_address == '0), "address on failed transaction")
    `SOA_ASSERT_ALWAYS(a_free_bound, !rsp_valid || (rsp.free_frames <= 7'(soa_pkg::NUM_FRAMES)), "free frame count out of range")

endmodule
